@@ rtl/trcd_pkg.sv @@
// ----------------------------------------------------------------------------
// trcd_pkg
// Shared types and constants of the tri-state remote code decoder: pulse
// classification word, window configuration and symbol codes.
// ----------------------------------------------------------------------------
package trcd_pkg;

    // symbol codes as stored in the history
    localparam logic [1:0] SYM_ZERO  = 2'd0;
    localparam logic [1:0] SYM_ONE   = 2'd1;
    localparam logic [1:0] SYM_FLOAT = 2'd2;
    localparam logic [1:0] SYM_EMPTY = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_ADDRESS_CODE = 3'd0;
    localparam logic [2:0] REG_SHORT_MIN    = 3'd1;
    localparam logic [2:0] REG_SHORT_MAX    = 3'd2;
    localparam logic [2:0] REG_LONG_MIN     = 3'd3;
    localparam logic [2:0] REG_LONG_MAX     = 3'd4;
    localparam logic [2:0] REG_PERIOD_MIN   = 3'd5;
    localparam logic [2:0] REG_PERIOD_MAX   = 3'd6;

    // fixed widths
    localparam int TIME_W = 16;
    localparam int ADDR_CODE_W = 24;
    localparam int ADDR_WIDE_W = 64;

    // register reset values
    localparam logic [TIME_W-1:0] SHORT_MIN_RST  = 16'd380;
    localparam logic [TIME_W-1:0] SHORT_MAX_RST  = 16'd450;
    localparam logic [TIME_W-1:0] LONG_MIN_RST   = 16'd1350;
    localparam logic [TIME_W-1:0] LONG_MAX_RST   = 16'd1430;
    localparam logic [TIME_W-1:0] PERIOD_MIN_RST = 16'd1880;
    localparam logic [TIME_W-1:0] PERIOD_MAX_RST = 16'd1950;

    // sync period window, exclusive bounds
    localparam logic [TIME_W-1:0] SYNC_MIN = 16'd15000;
    localparam logic [TIME_W-1:0] SYNC_MAX = 16'd16000;

    // depth of the queue between front and back, as address bits
    localparam int QUEUE_ADDR_W = 1;

    // high time and period windows
    typedef struct packed {
        logic [TIME_W-1:0] short_min;
        logic [TIME_W-1:0] short_max;
        logic [TIME_W-1:0] long_min;
        logic [TIME_W-1:0] long_max;
        logic [TIME_W-1:0] period_min;
        logic [TIME_W-1:0] period_max;
    } t_windows;

    // classification of one pulse, with the raw times kept as the next
    // previous pulse
    typedef struct packed {
        logic [TIME_W-1:0] high_width;
        logic [TIME_W-1:0] period;
        logic period_ok;
        logic is_long;
        logic is_short;
        logic sync_period;
    } t_class;

endpackage

@@ rtl/trcd_front.sv @@
// ----------------------------------------------------------------------------
// trcd_front
// Input side: accepts pulse words and classifies them against the windows,
// writing one classification word per pulse into the queue.
// ----------------------------------------------------------------------------
module trcd_front (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [trcd_pkg::TIME_W-1:0]     i_high_width,
    input  logic [trcd_pkg::TIME_W-1:0]     i_period,
    input  trcd_pkg::t_windows              i_windows,
    input  logic                            i_queue_full,
    output logic                            o_push,
    output trcd_pkg::t_class                o_class
);

    // strict window test
    function automatic logic in_window(
        input logic [trcd_pkg::TIME_W-1:0] v,
        input logic [trcd_pkg::TIME_W-1:0] lo,
        input logic [trcd_pkg::TIME_W-1:0] hi
    );
        return (v > lo) && (v < hi);
    endfunction

    // take a word whenever the queue has room
    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // window compares
    always_comb begin
        o_class.high_width  = i_high_width;
        o_class.period      = i_period;
        o_class.period_ok   = in_window(i_period, i_windows.period_min,
                                        i_windows.period_max);
        o_class.is_long     = in_window(i_high_width, i_windows.long_min,
                                        i_windows.long_max);
        o_class.is_short    = in_window(i_high_width, i_windows.short_min,
                                        i_windows.short_max);
        o_class.sync_period = in_window(i_period, trcd_pkg::SYNC_MIN,
                                        trcd_pkg::SYNC_MAX);
    end

endmodule

@@ rtl/trcd_fifo.sv @@
// ----------------------------------------------------------------------------
// trcd_fifo
// Short queue of classification words between the front and the back.
// ----------------------------------------------------------------------------
module trcd_fifo #(
    parameter int ADDR_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  trcd_pkg::t_class   i_class,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output trcd_pkg::t_class   o_class
);

    localparam int DEPTH = 1 << ADDR_W;
    localparam logic [ADDR_W:0] DEPTH_C = (ADDR_W + 1)'(DEPTH);

    trcd_pkg::t_class  r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [ADDR_W:0]   r_count;
    logic [ADDR_W:0]   n_count;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);
    assign o_class = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_class;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count out of range");

endmodule

@@ rtl/trcd_back.sv @@
// ----------------------------------------------------------------------------
// trcd_back
// Decode side: pairs each classified pulse with the previous one, keeps the
// symbol history, checks sync against the address and registers the result.
// ----------------------------------------------------------------------------
module trcd_back #(
    parameter int SYMBOL_COUNT = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  trcd_pkg::t_class                     i_class,
    output logic                                 o_pop,
    input  logic [trcd_pkg::ADDR_CODE_W-1:0]     i_address_code,
    input  trcd_pkg::t_windows                   i_windows,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [7:0]                           o_data
);

    logic [trcd_pkg::TIME_W-1:0] r_prev_width;
    logic [trcd_pkg::TIME_W-1:0] r_prev_period;
    logic [trcd_pkg::TIME_W-1:0] n_prev_width;
    logic [trcd_pkg::TIME_W-1:0] n_prev_period;
    logic [1:0]       r_hist [SYMBOL_COUNT];
    logic [1:0]       n_hist [SYMBOL_COUNT];
    logic             r_out_valid;
    logic [7:0]       r_out_data;

    logic [trcd_pkg::ADDR_WIDE_W-1:0] addr_wide;
    logic       sym_valid;
    logic [1:0] sym;
    logic       sync_seen;
    logic       match;

    // strict window test
    function automatic logic in_window(
        input logic [trcd_pkg::TIME_W-1:0] v,
        input logic [trcd_pkg::TIME_W-1:0] lo,
        input logic [trcd_pkg::TIME_W-1:0] hi
    );
        return (v > lo) && (v < hi);
    endfunction

    // pop whenever the output register is free or being emptied
    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    assign addr_wide = {{(trcd_pkg::ADDR_WIDE_W - trcd_pkg::ADDR_CODE_W){1'b0}},
                        i_address_code};

    // symbol pairing, sync detection and address compare
    always_comb begin
        logic prev_period_ok;
        logic prev_long;
        logic prev_short;
        logic pair;
        logic is_one;
        logic is_zero;
        logic is_float;
        // previous pulse is judged against the windows in force now
        prev_period_ok = in_window(r_prev_period, i_windows.period_min,
                                   i_windows.period_max);
        prev_long  = in_window(r_prev_width, i_windows.long_min, i_windows.long_max);
        prev_short = in_window(r_prev_width, i_windows.short_min, i_windows.short_max);
        pair     = i_class.period_ok && prev_period_ok;
        is_one   = pair && i_class.is_long && prev_long;
        is_zero  = pair && i_class.is_short && prev_short;
        is_float = pair && prev_short && i_class.is_long;
        sym_valid = is_one || is_zero || is_float;
        if (is_one) begin
            sym = trcd_pkg::SYM_ONE;
        end else if (is_zero) begin
            sym = trcd_pkg::SYM_ZERO;
        end else if (is_float) begin
            sym = trcd_pkg::SYM_FLOAT;
        end else begin
            sym = trcd_pkg::SYM_ZERO;
        end
        sync_seen = !sym_valid && i_class.sync_period && i_class.is_short;
        match = sync_seen;
        for (int k = 0; k < SYMBOL_COUNT; k++) begin
            if (r_hist[k] != addr_wide[2*k +: 2]) begin
                match = 1'b0;
            end
        end
    end

    // next previous-pulse and history
    always_comb begin
        n_prev_width  = (sym_valid || sync_seen) ? '0 : i_class.high_width;
        n_prev_period = (sym_valid || sync_seen) ? '0 : i_class.period;
        for (int k = 0; k < SYMBOL_COUNT - 1; k++) begin
            n_hist[k] = sym_valid ? r_hist[k + 1] : r_hist[k];
        end
        n_hist[SYMBOL_COUNT - 1] = sym_valid ? sym : r_hist[SYMBOL_COUNT - 1];
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_width  <= '0;
            r_prev_period <= '0;
            for (int k = 0; k < SYMBOL_COUNT; k++) begin
                r_hist[k] <= trcd_pkg::SYM_EMPTY;
            end
        end else if (o_pop) begin
            r_prev_width  <= n_prev_width;
            r_prev_period <= n_prev_period;
            for (int k = 0; k < SYMBOL_COUNT; k++) begin
                r_hist[k] <= n_hist[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {3'b000, match, sync_seen, sym, sym_valid};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_symbol_not_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[3]))
        else $error("symbol and sync reported for the same pulse");
    a_match_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[4]) |-> r_out_data[3])
        else $error("address match without sync");
    a_symbol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[0] ? (r_out_data[2:1] != trcd_pkg::SYM_EMPTY)
                                       : (r_out_data[2:1] == trcd_pkg::SYM_ZERO)))
        else $error("bad symbol code");
    a_cleared_after_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (sym_valid || sync_seen)) |=>
            ((r_prev_width == '0) && (r_prev_period == '0)))
        else $error("previous pulse not cleared");

endmodule

@@ rtl/tristate_remote_code_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tristate_remote_code_decoder_top
// Decodes tri-state remote control symbols from measured pulses.
//
// Usage:
//   s_axis carries one pulse word per beat: high time and period in timer
//   ticks. m_axis returns exactly one result word per pulse: symbol flag,
//   symbol code, sync flag and address match flag.
//   The configuration channel writes the address code and the six timing
//   windows; write it only while no pulse is in flight. It is always ready.
//   Throughput is one pulse per cycle while m_axis_tready stays high. An
//   accepted pulse is classified and written into a two-entry queue; the
//   back end pops it, decodes it and registers the result word in its
//   output register, which drives m_axis until the receiver takes it.
//   When the receiver stalls, the result holds in the output register, the
//   queue fills and s_axis_tready drops once both queue entries are taken.
//   Synchronous reset empties the queue and output, clears the previous
//   pulse, marks every history slot empty and loads the default windows.
// ----------------------------------------------------------------------------
module tristate_remote_code_decoder_top #(
    parameter int SYMBOL_COUNT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pulse input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] high_width, [31:16] period
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] symbol_valid, [2:1] symbol,
                                       // [3] sync_seen, [4] address_match
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [trcd_pkg::ADDR_CODE_W-1:0] r_address_code;
    trcd_pkg::t_windows               r_windows;

    logic             queue_full;
    logic             queue_empty;
    logic             push;
    logic             pop;
    trcd_pkg::t_class front_class;
    trcd_pkg::t_class queue_class;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_code       <= '0;
            r_windows.short_min  <= trcd_pkg::SHORT_MIN_RST;
            r_windows.short_max  <= trcd_pkg::SHORT_MAX_RST;
            r_windows.long_min   <= trcd_pkg::LONG_MIN_RST;
            r_windows.long_max   <= trcd_pkg::LONG_MAX_RST;
            r_windows.period_min <= trcd_pkg::PERIOD_MIN_RST;
            r_windows.period_max <= trcd_pkg::PERIOD_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                trcd_pkg::REG_ADDRESS_CODE: r_address_code <= i_cfg_data;
                trcd_pkg::REG_SHORT_MIN:  r_windows.short_min  <= i_cfg_data[15:0];
                trcd_pkg::REG_SHORT_MAX:  r_windows.short_max  <= i_cfg_data[15:0];
                trcd_pkg::REG_LONG_MIN:   r_windows.long_min   <= i_cfg_data[15:0];
                trcd_pkg::REG_LONG_MAX:   r_windows.long_max   <= i_cfg_data[15:0];
                trcd_pkg::REG_PERIOD_MIN: r_windows.period_min <= i_cfg_data[15:0];
                trcd_pkg::REG_PERIOD_MAX: r_windows.period_max <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // classify incoming pulses
    trcd_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_high_width (s_axis_tdata[15:0]),
        .i_period     (s_axis_tdata[31:16]),
        .i_windows    (r_windows),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_class      (front_class)
    );

    // queue between front and back
    trcd_fifo #(
        .ADDR_W (trcd_pkg::QUEUE_ADDR_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_class (front_class),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_class (queue_class)
    );

    // decode symbols and sync
    trcd_back #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (queue_empty),
        .i_class        (queue_class),
        .o_pop          (pop),
        .i_address_code (r_address_code),
        .i_windows      (r_windows),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata)
    );

endmodule
